// ===== design/cwrc_pkg.sv =====
// Shared types and constants for the congestion window / RTO controller.
// Used by the channel interfaces and by the top level.
`timescale 1ns / 1ps

package cwrc_pkg;

  typedef logic [15:0] count_t;
  typedef logic [15:0] seconds_t;
  typedef logic [18:0] timeout_t;
  typedef logic [15:0] cfg_data_t;
  typedef logic        cfg_index_t;

  // Configuration register indexes
  localparam cfg_index_t CFG_RECEIVER_WINDOW   = 1'b0;
  localparam cfg_index_t CFG_INITIAL_THRESHOLD = 1'b1;

  localparam cfg_data_t RECEIVER_WINDOW_RESET   = 16'd65535;
  localparam cfg_data_t INITIAL_THRESHOLD_RESET = 16'd64;

  localparam int SRTT_RESET = 1;
  localparam int RTO_RESET  = 10;

endpackage

// ===== design/cwrc_if.sv =====
// Valid/ready channel interfaces: send-round items, per-round results and
// configuration writes. Depends on cwrc_pkg.
`timescale 1ns / 1ps

interface cwrc_round_if;
  import cwrc_pkg::*;
  logic     valid;
  logic     ready;
  count_t   sent_count;
  count_t   acked_count;
  logic     sample_valid;
  seconds_t rtt_sample;

  modport source (output valid, sent_count, acked_count, sample_valid, rtt_sample,
                  input ready);
  modport sink   (input valid, sent_count, acked_count, sample_valid, rtt_sample,
                  output ready);
endinterface

interface cwrc_result_if;
  import cwrc_pkg::*;
  logic     valid;
  logic     ready;
  count_t   next_window;
  count_t   next_threshold;
  logic     avoidance_mode;
  timeout_t timeout_value;
  logic     give_up;

  modport source (output valid, next_window, next_threshold, avoidance_mode,
                  timeout_value, give_up, input ready);
  modport sink   (input valid, next_window, next_threshold, avoidance_mode,
                  timeout_value, give_up, output ready);
endinterface

interface cwrc_cfg_if;
  import cwrc_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/congestion_window_rto_controller_unit.sv =====
// Top level: congestion window, slow start threshold and retransmit timeout
// controller. Depends on cwrc_pkg and the channel interfaces in cwrc_if.sv.
`timescale 1ns / 1ps

// Usage:
//   round  - one transaction per send round: packets sent, packets acked in
//            order, and an optional round-trip sample in seconds.
//   result - one transaction per round: window, threshold, mode, timeout
//            and the give-up flag after that round.
//   cfg    - register writes: index 0 receiver window (caps the threshold),
//            index 1 initial threshold (also loads the threshold at once).
//            Always ready; write only while no round is outstanding.
// Latency: the result is valid in the cycle after the round is accepted.
// Throughput: one round per cycle while results are taken; the whole
// update is one combinational pass from the state registers and the round
// payload into the state and the result register.
// Reset (rst, synchronous): window 1, threshold 64, slow start, smoothed
// RTT 1, deviation 0, timeout 10, receiver window 65535, no result pending.
// Stall: the result register holds while result.ready is low; round.ready
// is low only while a result is held and not taken in that cycle.
// After a give-up rounds leave the state frozen; every round reports it.
module congestion_window_rto_controller_unit #(
  parameter int WINDOW_BITS = 16,
  parameter int TIME_BITS   = 16
) (
  input logic          clk,
  input logic          rst,
  cwrc_round_if.sink   round,
  cwrc_result_if.source result,
  cwrc_cfg_if.sink     cfg
);
  import cwrc_pkg::*;

  localparam int WB     = WINDOW_BITS;
  localparam int TB     = TIME_BITS;
  localparam int THR_W  = (WB > 16) ? WB : 16;
  localparam int RTO_W  = TB + 3;
  localparam int SCMP_W = (RTO_W > 16) ? RTO_W : 16;
  localparam int SMP_W  = (TB > 16) ? TB : 16;
  localparam int ROUT_W = (RTO_W > 19) ? RTO_W : 19;

  // State
  logic [WB-1:0]    window;
  logic [THR_W-1:0] threshold;
  logic             mode_avoid;
  logic [TB-1:0]    smoothed_rtt;
  logic [TB-1:0]    rtt_deviation;
  logic [RTO_W-1:0] retransmit_timeout;
  logic             zero_strike;
  logic             gave_up;
  cfg_data_t        receiver_window;
  logic             result_valid;

  logic [WB-1:0]    window_next;
  logic [THR_W-1:0] threshold_next;
  logic             mode_avoid_next;
  logic [TB-1:0]    smoothed_rtt_next;
  logic [TB-1:0]    rtt_deviation_next;
  logic [RTO_W-1:0] retransmit_timeout_next;
  logic             zero_strike_next;
  logic             gave_up_next;

  logic accept;
  logic cfg_write;

  // Datapath intermediates
  logic [THR_W-1:0] thr_clamped;
  logic [SMP_W-1:0] sample_ext;
  logic [TB-1:0]    sample_sat;
  logic             sample_use;
  logic [RTO_W-1:0] srtt_sum;
  logic [TB-1:0]    srtt_upd;
  logic [TB-1:0]    diff;
  logic [TB+1:0]    dev_sum;
  logic [TB-1:0]    dev_upd;
  logic             full;
  logic [THR_W-1:0] window_out;
  logic [ROUT_W-1:0] rto_out;

  assign accept    = round.valid && round.ready;
  assign cfg_write = cfg.valid && cfg.ready;

  assign round.ready  = !result_valid || result.ready;
  assign cfg.ready    = 1'b1;
  assign result.valid = result_valid;

  always_comb begin
    thr_clamped = (threshold > THR_W'(receiver_window)) ? THR_W'(receiver_window)
                                                       : threshold;

    // Sample saturates to the time field before use; the gate uses it raw.
    sample_ext = SMP_W'(round.rtt_sample);
    sample_sat = (sample_ext > SMP_W'({TB{1'b1}})) ? {TB{1'b1}} : sample_ext[TB-1:0];
    sample_use = round.sample_valid &&
                 (SCMP_W'(round.rtt_sample) <= SCMP_W'(retransmit_timeout));

    // srtt = (7*srtt + s) / 8
    srtt_sum = (RTO_W'(smoothed_rtt) << 3) - RTO_W'(smoothed_rtt) + RTO_W'(sample_sat);
    srtt_upd = srtt_sum[RTO_W-1:3];
    diff     = (srtt_upd >= sample_sat) ? (srtt_upd - sample_sat) : (sample_sat - srtt_upd);
    // dev = (3*dev + |srtt - s|) / 4
    dev_sum  = (TB+2)'({rtt_deviation, 1'b0}) + (TB+2)'(rtt_deviation) + (TB+2)'(diff);
    dev_upd  = dev_sum[TB+1:2];

    full = round.acked_count >= round.sent_count;

    window_next             = window;
    threshold_next          = threshold;
    mode_avoid_next         = mode_avoid;
    smoothed_rtt_next       = smoothed_rtt;
    rtt_deviation_next      = rtt_deviation;
    retransmit_timeout_next = retransmit_timeout;
    zero_strike_next        = zero_strike;
    gave_up_next            = gave_up;

    if (!gave_up) begin
      threshold_next = thr_clamped;
      if (sample_use) begin
        smoothed_rtt_next       = srtt_upd;
        rtt_deviation_next      = dev_upd;
        retransmit_timeout_next = RTO_W'(srtt_upd) + RTO_W'({dev_upd, 2'b00});
      end
      if (round.acked_count == '0 && zero_strike) begin
        gave_up_next = 1'b1;
      end else begin
        if (round.acked_count == '0) begin
          zero_strike_next = 1'b1;
        end
        priority if (!full) begin
          // loss: threshold from half the window, back to slow start
          threshold_next  = THR_W'(window[WB-1:1]);
          window_next     = WB'(1);
          mode_avoid_next = 1'b0;
        end else if (!mode_avoid) begin
          if (THR_W'(window) < thr_clamped) begin
            window_next = window[WB-1] ? {WB{1'b1}} : {window[WB-2:0], 1'b0};
          end else begin
            mode_avoid_next = 1'b1;
          end
        end else begin
          // avoidance: grow by one, holding at the window maximum
          if (window != {WB{1'b1}}) begin
            window_next = window + WB'(1);
          end
        end
      end
    end

    window_out = THR_W'(window_next);
    rto_out    = ROUT_W'(retransmit_timeout_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window             <= WB'(1);
      threshold          <= THR_W'(INITIAL_THRESHOLD_RESET);
      mode_avoid         <= 1'b0;
      smoothed_rtt       <= TB'(SRTT_RESET);
      rtt_deviation      <= '0;
      retransmit_timeout <= RTO_W'(RTO_RESET);
      zero_strike        <= 1'b0;
      gave_up            <= 1'b0;
      receiver_window    <= RECEIVER_WINDOW_RESET;
      result_valid       <= 1'b0;
    end else begin
      if (accept) begin
        window             <= window_next;
        threshold          <= threshold_next;
        mode_avoid         <= mode_avoid_next;
        smoothed_rtt       <= smoothed_rtt_next;
        rtt_deviation      <= rtt_deviation_next;
        retransmit_timeout <= retransmit_timeout_next;
        zero_strike        <= zero_strike_next;
        gave_up            <= gave_up_next;
      end
      if (cfg_write) begin
        unique case (cfg.index)
          CFG_RECEIVER_WINDOW:   receiver_window <= cfg.data;
          CFG_INITIAL_THRESHOLD: threshold       <= THR_W'(cfg.data);
          default: ;
        endcase
      end
      if (accept) begin
        result_valid <= 1'b1;
      end else if (result.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result register: payload only, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      result.next_window    <= window_out[15:0];
      result.next_threshold <= threshold_next[15:0];
      result.avoidance_mode <= mode_avoid_next;
      result.timeout_value  <= rto_out[18:0];
      result.give_up        <= gave_up_next;
    end
  end

`ifndef SYNTHESIS
  a_window_nonzero: assert property (@(posedge clk) disable iff (rst)
    window != '0)
    else $error("window reached zero");

  a_give_up_sticky: assert property (@(posedge clk) disable iff (rst)
    gave_up |=> gave_up)
    else $error("give-up flag cleared");

  a_frozen_after_give_up: assert property (@(posedge clk) disable iff (rst)
    (gave_up && !cfg_write) |=> ($stable(window) && $stable(threshold) &&
                                 $stable(retransmit_timeout)))
    else $error("state moved after give-up");

  a_result_follows_round: assert property (@(posedge clk) disable iff (rst)
    accept |=> (result_valid && result.give_up == gave_up))
    else $error("result missing or inconsistent after a round");

  a_threshold_capped: assert property (@(posedge clk) disable iff (rst)
    (accept && !gave_up && !cfg_write && full && round.acked_count != '0)
      |=> (threshold <= THR_W'(receiver_window)))
    else $error("threshold above receiver window after a round");
`endif

endmodule
